FILE: rtl/core/sli_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sli_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_DUMP   = 2'd2;

   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_FULL   = 2'd1;
   localparam logic [1:0] STAT_EMPTY  = 2'd2;
   localparam logic [1:0] STAT_ABSENT = 2'd3;

   typedef struct packed {
      logic [1:0]          command;
      logic signed [31:0]  value;
   } sli_req_type;

   typedef struct packed {
      logic [1:0]          status;
      logic signed [31:0]  entry_value;
      logic [3:0]          position;
      logic [4:0]          entry_count;
      logic                last;
   } sli_rsp_type;

   typedef struct packed {
      logic                wr_en;
      logic [IDX_W-1:0]    wr_addr;
      logic [31:0]         wr_data;
      logic [IDX_W-1:0]    rd_addr;
   } sli_store_req_type;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_INS  = 5'b00010,
      ST_PUT  = 5'b00100,
      ST_RMV  = 5'b01000,
      ST_DUMP = 5'b10000
   } sli_state_type;

endpackage

`default_nettype wire

FILE: rtl/core/sorted_list_insert_delete.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Ports                        Handshake
// request  start, busy, req_item        beat taken when start && !busy
// result   rsp_strobe, rsp_item         beat valid for one cycle, never held off
//
// Insert walks the list from the top down, one entry per cycle, moving each entry
// not below the new value up one slot.
// Remove scans up from slot 0 and closes the gap behind the match.
// Dump gives one result per cycle; one store read per cycle sets all.
// Reset clears the entry count and the sequencer; stored entries keep old contents.
// busy stays high while a command walks the store; results cannot be stalled.

module sorted_list_insert_delete (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire sli_pkg::sli_req_type req_item,
   output logic                      rsp_strobe,
   output sli_pkg::sli_rsp_type      rsp_item
);
   import sli_pkg::*;

   sli_state_type     state_ff, state_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              found_ff, found_in;
   logic [31:0]       val_ff, val_in;
   logic              strobe_ff, strobe_in;
   sli_rsp_type       rsp_ff, rsp_in;
   sli_store_req_type store_req;
   logic [31:0]       rd_data_ff;
   logic              at_top;
   logic              match;

   sli_store u_store (
      .clock      (clock),
      .store_req  (store_req),
      .rd_data_ff (rd_data_ff)
   );

   assign at_top = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;
   assign match  = rd_data_ff == val_ff;

   always_comb begin
      state_in          = state_ff;
      idx_in            = idx_ff;
      count_in          = count_ff;
      found_in          = found_ff;
      val_in            = val_ff;
      strobe_in         = 1'b0;
      rsp_in            = '0;
      store_req.wr_en   = 1'b0;
      store_req.wr_addr = idx_ff + IDX_W'(1);
      store_req.wr_data = rd_data_ff;
      store_req.rd_addr = idx_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               val_in   = req_item.value;
               found_in = 1'b0;
               case (req_item.command)
                  CMD_INSERT: begin
                     if (count_ff >= CNT_W'(CAPACITY)) begin
                        strobe_in          = 1'b1;
                        rsp_in.status      = STAT_FULL;
                        rsp_in.entry_count = 5'(count_ff);
                        rsp_in.last        = 1'b1;
                     end else if (count_ff == '0) begin
                        idx_in   = '0;
                        state_in = ST_PUT;
                     end else begin
                        idx_in            = IDX_W'(count_ff - CNT_W'(1));
                        store_req.rd_addr = IDX_W'(count_ff - CNT_W'(1));
                        state_in          = ST_INS;
                     end
                  end
                  CMD_REMOVE, CMD_DUMP: begin
                     if (count_ff == '0) begin
                        strobe_in          = 1'b1;
                        rsp_in.status      = STAT_EMPTY;
                        rsp_in.entry_count = 5'(count_ff);
                        rsp_in.last        = 1'b1;
                     end else begin
                        idx_in            = '0;
                        store_req.rd_addr = '0;
                        state_in          = (req_item.command == CMD_DUMP) ? ST_DUMP : ST_RMV;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_INS: begin
            store_req.wr_en   = 1'b1;
            store_req.wr_addr = idx_ff + IDX_W'(1);
            if ($signed(rd_data_ff) >= $signed(val_ff)) begin
               store_req.wr_data = rd_data_ff;
               if (idx_ff == '0) begin
                  state_in = ST_PUT;
               end else begin
                  idx_in            = idx_ff - IDX_W'(1);
                  store_req.rd_addr = idx_ff - IDX_W'(1);
               end
            end else begin
               store_req.wr_data  = val_ff;
               count_in           = count_ff + CNT_W'(1);
               strobe_in          = 1'b1;
               rsp_in.status      = STAT_OK;
               rsp_in.entry_count = 5'(count_in);
               rsp_in.last        = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         ST_PUT: begin
            store_req.wr_en    = 1'b1;
            store_req.wr_addr  = idx_ff;
            store_req.wr_data  = val_ff;
            count_in           = count_ff + CNT_W'(1);
            strobe_in          = 1'b1;
            rsp_in.status      = STAT_OK;
            rsp_in.entry_count = 5'(count_in);
            rsp_in.last        = 1'b1;
            state_in           = ST_IDLE;
         end
         ST_RMV: begin
            store_req.wr_en   = found_ff;
            store_req.wr_addr = idx_ff - IDX_W'(1);
            store_req.wr_data = rd_data_ff;
            found_in          = found_ff | match;
            if (at_top) begin
               count_in           = found_in ? count_ff - CNT_W'(1) : count_ff;
               strobe_in          = 1'b1;
               rsp_in.status      = found_in ? STAT_OK : STAT_ABSENT;
               rsp_in.entry_count = 5'(count_in);
               rsp_in.last        = 1'b1;
               state_in           = ST_IDLE;
            end else begin
               idx_in            = idx_ff + IDX_W'(1);
               store_req.rd_addr = idx_ff + IDX_W'(1);
            end
         end
         ST_DUMP: begin
            strobe_in          = 1'b1;
            rsp_in.status      = STAT_OK;
            rsp_in.entry_value = rd_data_ff;
            rsp_in.position    = 4'(idx_ff);
            rsp_in.entry_count = 5'(count_ff);
            rsp_in.last        = at_top;
            if (at_top) begin
               state_in = ST_IDLE;
            end else begin
               idx_in            = idx_ff + IDX_W'(1);
               store_req.rd_addr = idx_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
         found_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
         found_ff  <= found_in;
      end
      idx_ff <= idx_in;
      val_ff <= val_in;
      rsp_ff <= rsp_in;
   end

   assign busy       = state_ff != ST_IDLE;
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.last |-> busy)
      else $error("dump beat ended without a last marker");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.last |-> !busy)
      else $error("last beat sent while command still active");

   assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_item.command == CMD_INSERT || req_item.command == CMD_REMOVE
         || req_item.command == CMD_DUMP) |=> rsp_strobe || busy)
      else $error("command dropped");

endmodule

`default_nettype wire

FILE: rtl/core/sli_store.sv
`timescale 1ns / 1ps
`default_nettype none

module sli_store (
   input  wire logic                       clock,
   input  wire sli_pkg::sli_store_req_type store_req,
   output logic [31:0]                     rd_data_ff
);
   import sli_pkg::*;

   logic [31:0] mem_ff [CAPACITY];

   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         mem_ff[store_req.wr_addr] <= store_req.wr_data;
      end
      rd_data_ff <= mem_ff[store_req.rd_addr];
   end

endmodule

`default_nettype wire
